// ===== src/h2r_pkg.sv =====
// h2r_pkg: shared types and constants for the HSL to RGB565 converter.
// Used by h2r_recip and hsl_to_rgb565. No dependencies.
`default_nettype none

package h2r_pkg;

    // Hue handling
    localparam int unsigned HUE_W     = 9;
    localparam logic [8:0]  HUE_FULL  = 9'd360;
    localparam logic [8:0]  HUE_TWO3  = 9'd240;
    localparam logic [8:0]  HUE_THIRD = 9'd120;
    localparam logic [8:0]  HUE_SEXT  = 9'd60;
    localparam logic [8:0]  HUE_SEXT3 = 9'd180;
    localparam logic [8:0]  HUE_SEXT5 = 9'd300;

    // Fixed point: all terms in units of 1/(2*255*255*60)
    localparam int unsigned BYTE_W    = 8;
    localparam logic [8:0]  HALF_PT   = 9'd255;     // compare point for 2*l
    localparam logic [8:0]  FULL_PT   = 9'd510;
    localparam logic [14:0] SCALE_DIV = 15'd30600;  // one channel LSB
    localparam int unsigned DS_W      = 16;         // d*s
    localparam int unsigned TERM_W    = 23;         // c, x, base terms
    localparam logic [6:0]  C_MULT    = 7'd120;
    localparam logic [6:0]  M_MULT    = 7'd60;
    localparam int unsigned T_W       = 6;          // secondary weight 0..60

    // Channel sum and its division by SCALE_DIV (exact reciprocal multiply)
    localparam int unsigned NUM_W       = 24;
    localparam int unsigned QUOT_W      = 10;
    localparam int unsigned RECIP_SHIFT = 39;       // NUM_W + ceil(log2(SCALE_DIV))
    localparam int unsigned RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));
    localparam int unsigned PROD_W      = NUM_W + RECIP_W;
    localparam logic [QUOT_W-1:0] BYTE_MAX = QUOT_W'(255);

    localparam int unsigned RGB_W = 16;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

`default_nettype wire

// ===== src/h2r_recip.sv =====
// h2r_recip: one pipeline stage that divides a channel sum by SCALE_DIV.
// Exact floor division by reciprocal multiply; depends on h2r_pkg.
`default_nettype none

module h2r_recip (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [h2r_pkg::NUM_W-1:0]    i_num,
    output logic      [h2r_pkg::QUOT_W-1:0]   o_quot
);
    import h2r_pkg::*;

    logic [PROD_W-1:0] n_prod;
    logic [QUOT_W-1:0] r_quot;

    // floor(n*K / 2^SHIFT) == floor(n / SCALE_DIV) for all n < 2^NUM_W
    assign n_prod = PROD_W'(i_num) * PROD_W'(RECIP_K);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== src/hsl_to_rgb565.sv =====
// hsl_to_rgb565: pipelined HSL (degrees, 8-bit S and L) to RGB565 converter.
// Depends on h2r_pkg and h2r_recip.
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_ready     i_hue_deg[8:0], i_saturation[7:0],
//                                            i_lightness[7:0]
// output    out        o_valid / i_ready     o_rgb565[15:0]
//
// Six register stages; one color per cycle sustained while the output does not stall.
// Each stage has its own valid bit and moves when it is empty or the stage after
// it moves, so bubbles are squeezed out and a stall loses nothing.
// o_ready is low only when all six stages hold an item and i_ready is low.
// Reset (synchronous, active low) clears the valid bits; data registers are not reset.
//
// Stages:
//   1  hue wrap, sector, secondary weight t, d = 255 - |2l - 255|
//   2  d*s, l*30600
//   3  chroma term 120*ds, secondary term 2*ds*t, offset l*30600 - 60*ds
//   4  sector routing, per-channel sums
//   5  divide each sum by 30600 (reciprocal multiply, h2r_recip)
//   6  clamp to 255, pack 5-6-5 into the output register

module hsl_to_rgb565 (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [h2r_pkg::HUE_W-1:0]  i_hue_deg,
    input  wire logic [h2r_pkg::BYTE_W-1:0] i_saturation,
    input  wire logic [h2r_pkg::BYTE_W-1:0] i_lightness,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [h2r_pkg::RGB_W-1:0]  o_rgb565
);
    import h2r_pkg::*;

    localparam int unsigned NSTG = 6;

    // Stage control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] stg_rdy;

    // Stage 1
    logic [HUE_W-1:0]  s1_hw;
    logic [HUE_W-1:0]  s1_hm;
    logic [HUE_W-1:0]  s1_l2;
    logic [T_W-1:0]    n1_t;
    logic [BYTE_W-1:0] n1_d;
    t_sector           n1_sec;
    logic [T_W-1:0]    r1_t;
    logic [BYTE_W-1:0] r1_d;
    logic [BYTE_W-1:0] r1_s;
    logic [BYTE_W-1:0] r1_l;
    t_sector           r1_sec;

    // Stage 2
    logic [DS_W-1:0]   r2_ds;
    logic [TERM_W-1:0] r2_lb;
    logic [T_W-1:0]    r2_t;
    t_sector           r2_sec;

    // Stage 3
    logic [TERM_W-1:0] r3_c;
    logic [TERM_W-1:0] r3_x;
    logic [TERM_W-1:0] r3_base;
    t_sector           r3_sec;

    // Stage 4
    logic [TERM_W-1:0] n4_rc;
    logic [TERM_W-1:0] n4_gc;
    logic [TERM_W-1:0] n4_bc;
    logic [NUM_W-1:0]  r4_nr;
    logic [NUM_W-1:0]  r4_ng;
    logic [NUM_W-1:0]  r4_nb;

    // Stage 5 (inside h2r_recip)
    logic [QUOT_W-1:0] q5_r;
    logic [QUOT_W-1:0] q5_g;
    logic [QUOT_W-1:0] q5_b;

    // Stage 6
    logic [BYTE_W-1:0] n6_r;
    logic [BYTE_W-1:0] n6_g;
    logic [BYTE_W-1:0] n6_b;
    logic [RGB_W-1:0]  r_rgb;

    // ---------------------------------------------------------------
    // Flow control: a stage may load when it is empty or its own item
    // leaves in the same cycle.
    // ---------------------------------------------------------------
    always_comb begin
        stg_rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (stg_rdy[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // ---------------------------------------------------------------
    // Stage 1: hue wrap, sector, t, d
    // ---------------------------------------------------------------
    always_comb begin
        s1_hw = (i_hue_deg >= HUE_FULL) ? (i_hue_deg - HUE_FULL) : i_hue_deg;

        if (s1_hw < HUE_SEXT) begin
            n1_sec = SEC_RED_YEL;
        end else if (s1_hw < HUE_THIRD) begin
            n1_sec = SEC_YEL_GRN;
        end else if (s1_hw < HUE_SEXT3) begin
            n1_sec = SEC_GRN_CYN;
        end else if (s1_hw < HUE_TWO3) begin
            n1_sec = SEC_CYN_BLU;
        end else if (s1_hw < HUE_SEXT5) begin
            n1_sec = SEC_BLU_MAG;
        end else begin
            n1_sec = SEC_MAG_RED;
        end

        // hue mod 120, then distance from the nearest primary
        if (s1_hw >= HUE_TWO3) begin
            s1_hm = s1_hw - HUE_TWO3;
        end else if (s1_hw >= HUE_THIRD) begin
            s1_hm = s1_hw - HUE_THIRD;
        end else begin
            s1_hm = s1_hw;
        end
        n1_t = (s1_hm >= HUE_SEXT) ? T_W'(HUE_THIRD - s1_hm) : T_W'(s1_hm);

        s1_l2 = {i_lightness, 1'b0};
        n1_d  = (s1_l2 >= HALF_PT) ? BYTE_W'(FULL_PT - s1_l2) : BYTE_W'(s1_l2);
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r1_t   <= n1_t;
            r1_d   <= n1_d;
            r1_s   <= i_saturation;
            r1_l   <= i_lightness;
            r1_sec <= n1_sec;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: d*s and the lightness term
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r2_ds  <= DS_W'(r1_d) * DS_W'(r1_s);
            r2_lb  <= TERM_W'(r1_l) * TERM_W'(SCALE_DIV);
            r2_t   <= r1_t;
            r2_sec <= r1_sec;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: chroma, secondary and offset terms (offset is never negative)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r3_c    <= TERM_W'(r2_ds) * TERM_W'(C_MULT);
            r3_x    <= (TERM_W'(r2_ds) * TERM_W'(r2_t)) << 1;
            r3_base <= r2_lb - TERM_W'(r2_ds) * TERM_W'(M_MULT);
            r3_sec  <= r2_sec;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: route c and x by sector, add the offset
    // ---------------------------------------------------------------
    always_comb begin
        unique case (r3_sec)
            SEC_RED_YEL: begin
                n4_rc = r3_c;  n4_gc = r3_x;  n4_bc = '0;
            end
            SEC_YEL_GRN: begin
                n4_rc = r3_x;  n4_gc = r3_c;  n4_bc = '0;
            end
            SEC_GRN_CYN: begin
                n4_rc = '0;    n4_gc = r3_c;  n4_bc = r3_x;
            end
            SEC_CYN_BLU: begin
                n4_rc = '0;    n4_gc = r3_x;  n4_bc = r3_c;
            end
            SEC_BLU_MAG: begin
                n4_rc = r3_x;  n4_gc = '0;    n4_bc = r3_c;
            end
            default: begin
                n4_rc = r3_c;  n4_gc = '0;    n4_bc = r3_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r4_nr <= NUM_W'(r3_base) + NUM_W'(n4_rc);
            r4_ng <= NUM_W'(r3_base) + NUM_W'(n4_gc);
            r4_nb <= NUM_W'(r3_base) + NUM_W'(n4_bc);
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: channel byte = floor(sum / 30600)
    // ---------------------------------------------------------------
    h2r_recip u_recip_r (
        .i_clk  (i_clk),
        .i_en   (stg_rdy[4]),
        .i_num  (r4_nr),
        .o_quot (q5_r)
    );

    h2r_recip u_recip_g (
        .i_clk  (i_clk),
        .i_en   (stg_rdy[4]),
        .i_num  (r4_ng),
        .o_quot (q5_g)
    );

    h2r_recip u_recip_b (
        .i_clk  (i_clk),
        .i_en   (stg_rdy[4]),
        .i_num  (r4_nb),
        .o_quot (q5_b)
    );

    // ---------------------------------------------------------------
    // Stage 6: clamp and pack 5-6-5
    // ---------------------------------------------------------------
    assign n6_r = (q5_r > BYTE_MAX) ? BYTE_W'(BYTE_MAX) : BYTE_W'(q5_r);
    assign n6_g = (q5_g > BYTE_MAX) ? BYTE_W'(BYTE_MAX) : BYTE_W'(q5_g);
    assign n6_b = (q5_b > BYTE_MAX) ? BYTE_W'(BYTE_MAX) : BYTE_W'(q5_b);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[5]) begin
            r_rgb <= {n6_r[7:3], n6_g[7:2], n6_b[7:3]};
        end
    end

    assign o_rgb565 = r_rgb;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Input side blocks only with a completely full pipeline
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input blocked while pipeline has a free stage");

    // An input transfer always lands in stage 1
    a_enter_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item did not enter stage 1");

    // Exact arithmetic never exceeds a full byte
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (q5_r <= BYTE_MAX && q5_g <= BYTE_MAX && q5_b <= BYTE_MAX))
        else $error("channel quotient above 255");

endmodule

`default_nettype wire
